/* sv/assert_macros.svh */
// Assertion macros for the clock seven-segment renderer.
// Included by the RTL files that carry concurrent assertions; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* sv/cssr_pkg.sv */
// Package for the clock seven-segment renderer: payload structs, command
// codes, glyph table and small decimal helpers. No dependencies.
package cssr_pkg;

  localparam int unsigned Tubes = 6;

  typedef enum logic [1:0] {
    CMD_TIME = 2'd0,
    CMD_DATE = 2'd1,
    CMD_MSG  = 2'd2
  } cmd_e;

  localparam logic [7:0] CodeSpace = 8'h20;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [5:0]  seconds;
    logic [5:0]  minutes;
    logic [4:0]  hours;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [5:0]  dot_mask;
    logic [47:0] message_text;
  } item_t;

  typedef struct packed {
    logic [7:0] tube5_segments;
    logic [7:0] tube4_segments;
    logic [7:0] tube3_segments;
    logic [7:0] tube2_segments;
    logic [7:0] tube1_segments;
    logic [7:0] tube0_segments;
  } result_t;

  typedef logic [Tubes-1:0][7:0] codes_t;

  // tens digit of a value below 128 (only values below 100 reach it)
  function automatic logic [3:0] tens_of(input logic [6:0] v);
    logic [3:0] t;
    if (v >= 7'd90)      t = 4'd9;
    else if (v >= 7'd80) t = 4'd8;
    else if (v >= 7'd70) t = 4'd7;
    else if (v >= 7'd60) t = 4'd6;
    else if (v >= 7'd50) t = 4'd5;
    else if (v >= 7'd40) t = 4'd4;
    else if (v >= 7'd30) t = 4'd3;
    else if (v >= 7'd20) t = 4'd2;
    else if (v >= 7'd10) t = 4'd1;
    else                 t = 4'd0;
    return t;
  endfunction

  // segment byte a b c d e f g dp, MSB first
  function automatic logic [7:0] glyph(input logic [7:0] code);
    logic [7:0] s;
    case (code)
      8'd0:  s = 8'hFC;
      8'd1:  s = 8'h60;
      8'd2:  s = 8'hDA;
      8'd3:  s = 8'hF2;
      8'd4:  s = 8'h66;
      8'd5:  s = 8'hB6;
      8'd6:  s = 8'hBE;
      8'd7:  s = 8'hE0;
      8'd8:  s = 8'hFE;
      8'd9:  s = 8'hF6;
      8'h41: s = 8'hEE; // A
      8'h42: s = 8'h3E;
      8'h43: s = 8'h9C;
      8'h44: s = 8'h7A;
      8'h45: s = 8'h9E;
      8'h46: s = 8'h8E;
      8'h47: s = 8'hF6;
      8'h48: s = 8'h6E;
      8'h49: s = 8'h0C;
      8'h4A: s = 8'h70;
      8'h4C: s = 8'h1C; // L
      8'h4E: s = 8'h2A; // N
      8'h4F: s = 8'hFC;
      8'h50: s = 8'hCE;
      8'h51: s = 8'hE6;
      8'h52: s = 8'h0A;
      8'h53: s = 8'hB6;
      8'h54: s = 8'h1E;
      8'h55: s = 8'h38;
      8'h56: s = 8'h7C;
      8'h59: s = 8'h76; // Y
      8'h2E: s = 8'hC6; // degree ring
      8'h2D: s = 8'h02; // minus
      8'h30: s = 8'hFC; // ASCII zero
      default: s = 8'h00;
    endcase
    return s;
  endfunction

endpackage

/* sv/cssr_split.sv */
// Digit split for the clock renderer: turns one registered command into six
// character codes. Depends on cssr_pkg.
module cssr_split (
  input  cssr_pkg::item_t  item_i,
  input  logic             date_order_i,
  output cssr_pkg::codes_t codes_o
);

  logic [26:0] year_prod;
  logic [7:0]  year_hund;
  logic [13:0] year_rem_w;
  logic [6:0]  year_rem;
  logic [6:0]  dm_lo;
  logic [6:0]  dm_hi;

  // year / 100 by reciprocal, exact for all 14-bit years
  assign year_prod  = 27'(item_i.year) * 27'd5243;
  assign year_hund  = year_prod[26:19];
  assign year_rem_w = item_i.year - 14'(year_hund) * 14'd100;
  assign year_rem   = year_rem_w[6:0];

  assign dm_lo = date_order_i ? 7'(item_i.day) : 7'(item_i.month);
  assign dm_hi = date_order_i ? 7'(item_i.month) : 7'(item_i.day);

  function automatic logic [15:0] pair(input logic [6:0] v);
    logic [3:0] t;
    logic [6:0] u;
    t = cssr_pkg::tens_of(v);
    u = v - 7'(t) * 7'd10;
    return {4'd0, t, 4'd0, u[3:0]};
  endfunction

  always_comb begin
    for (int i = 0; i < cssr_pkg::Tubes; i++) begin
      codes_o[i] = cssr_pkg::CodeSpace;
    end
    case (item_i.cmd)
      cssr_pkg::CMD_TIME: begin
        {codes_o[1], codes_o[0]} = pair(7'(item_i.seconds));
        {codes_o[3], codes_o[2]} = pair(7'(item_i.minutes));
        {codes_o[5], codes_o[4]} = pair(7'(item_i.hours));
      end
      cssr_pkg::CMD_DATE: begin
        {codes_o[1], codes_o[0]} = pair(year_rem);
        {codes_o[3], codes_o[2]} = pair(dm_lo);
        {codes_o[5], codes_o[4]} = pair(dm_hi);
      end
      cssr_pkg::CMD_MSG: begin
        for (int k = 0; k < cssr_pkg::Tubes; k++) begin
          codes_o[cssr_pkg::Tubes-1-k] = item_i.message_text[8*k +: 8];
        end
      end
      default: begin
        // unused command: all tubes blank, dots only
      end
    endcase
  end

endmodule

/* sv/cssr_glyph.sv */
// Glyph mapping and decimal-point overlay for the clock renderer.
// Depends on cssr_pkg.
module cssr_glyph (
  input  cssr_pkg::codes_t  codes_i,
  input  logic [5:0]        dot_mask_i,
  output cssr_pkg::result_t result_o
);

  logic [cssr_pkg::Tubes-1:0][7:0] seg;

  always_comb begin
    for (int i = 0; i < cssr_pkg::Tubes; i++) begin
      seg[i] = cssr_pkg::glyph(codes_i[i]) | {7'd0, dot_mask_i[i]};
    end
  end

  assign result_o.tube0_segments = seg[0];
  assign result_o.tube1_segments = seg[1];
  assign result_o.tube2_segments = seg[2];
  assign result_o.tube3_segments = seg[3];
  assign result_o.tube4_segments = seg[4];
  assign result_o.tube5_segments = seg[5];

endmodule

/* sv/clock_seven_segment_renderer_core.sv */
// Top level of the clock seven-segment renderer: input register, digit split,
// glyph map and result register. Depends on cssr_pkg, cssr_split, cssr_glyph.
//
//  channel  | signals                              | transaction
//  ---------+--------------------------------------+----------------------------
//  command  | start, busy, item_i                  | start && !busy
//  result   | result_valid_o, result_o             | result_valid_o (one cycle)
//  config   | cfg_valid_i, cfg_ready_o, cfg_data_i | cfg_valid_i && cfg_ready_o
//
// One command per cycle; its result strobes once it has passed the input and result registers.
// busy stays low: the datapath is a fixed two-register pipeline.
// Reset clears the stage valids and date_order (day-month-year).
// The result cannot be stalled; config is to be written while the block is idle, which the block does not enforce.
`include "assert_macros.svh"
module clock_seven_segment_renderer_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  cssr_pkg::item_t   item_i,
  output logic              result_valid_o,
  output cssr_pkg::result_t result_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic              cfg_data_i
);

  logic              date_order_q;
  logic              in_valid_q;
  cssr_pkg::item_t   item_q;
  logic              out_valid_q;
  cssr_pkg::result_t result_q;
  cssr_pkg::codes_t  codes;
  cssr_pkg::result_t result_d;
  logic              accept;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      date_order_q <= 1'b0;
      in_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        date_order_q <= cfg_data_i;
      end
      in_valid_q  <= accept;
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
    if (in_valid_q) begin
      result_q <= result_d;
    end
  end

  cssr_split u_split (
    .item_i       (item_q),
    .date_order_i (date_order_q),
    .codes_o      (codes)
  );

  cssr_glyph u_glyph (
    .codes_i    (codes),
    .dot_mask_i (item_q.dot_mask),
    .result_o   (result_d)
  );

  assign result_valid_o = out_valid_q;
  assign result_o       = result_q;

  `ASSERT_NEXT(a_accept_fills, clk_i, rst_ni, accept, in_valid_q)
  `ASSERT_NEXT(a_stage_strobes, clk_i, rst_ni, in_valid_q, result_valid_o)
  `ASSERT_NEXT(a_no_spurious, clk_i, rst_ni, !in_valid_q, !result_valid_o)
  `ASSERT_IMPL(a_dot_overlay, clk_i, rst_ni, result_valid_o && $past(item_q.dot_mask[0]),
               result_o.tube0_segments[0])

endmodule

/* tb/segment_render_checker.sv */
// Checker for the clock seven-segment renderer: watches the command, result and
// date order channels, predicts the six tube bytes and compares them in order.
// Depends on cssr_pkg.
module segment_render_checker
  import cssr_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  input  logic    busy,
  input  item_t   item_i,
  input  logic    result_valid_o,
  input  result_t result_o,
  input  logic    cfg_valid_i,
  input  logic    cfg_ready_o,
  input  logic    cfg_data_i,
  output int      failures_o,
  output int      pending_o,
  output int      results_o
);

  localparam logic [7:0] BlankCode = " ";

  result_t    tube_bytes_q[$];
  logic       month_first;
  int         fail_count;
  int         checked_count;

  // {tens code, units code}
  function automatic logic [15:0] split_decimal(input int unsigned v);
    return {8'((v / 10) % 10), 8'(v % 10)};
  endfunction

  function automatic logic [7:0] segment_pattern(input logic [7:0] code);
    logic [7:0] s;
    case (code)
      8'd0, "O", "0": s = 8'hFC;
      8'd1:           s = 8'h60;
      8'd2:           s = 8'hDA;
      8'd3:           s = 8'hF2;
      8'd4:           s = 8'h66;
      8'd5, "S":      s = 8'hB6;
      8'd6:           s = 8'hBE;
      8'd7:           s = 8'hE0;
      8'd8:           s = 8'hFE;
      8'd9, "G":      s = 8'hF6;
      "A":            s = 8'hEE;
      "B":            s = 8'h3E;
      "C":            s = 8'h9C;
      "D":            s = 8'h7A;
      "E":            s = 8'h9E;
      "F":            s = 8'h8E;
      "H":            s = 8'h6E;
      "I":            s = 8'h0C;
      "J":            s = 8'h70;
      "L":            s = 8'h1C;
      "N":            s = 8'h2A;
      "P":            s = 8'hCE;
      "Q":            s = 8'hE6;
      "R":            s = 8'h0A;
      "T":            s = 8'h1E;
      "U":            s = 8'h38;
      "V":            s = 8'h7C;
      "Y":            s = 8'h76;
      ".":            s = 8'hC6; // upper ring
      "-":            s = 8'h02;
      default:        s = 8'h00;
    endcase
    return s;
  endfunction

  function automatic result_t render_tubes(input item_t it, input logic mdy);
    logic [5:0][7:0] codes;
    logic [5:0][7:0] tubes;
    logic            blank;
    int              k;
    blank = 1'b0;
    codes = {6{BlankCode}};
    case (it.cmd)
      CMD_TIME: begin
        codes[1:0] = split_decimal(32'(it.seconds));
        codes[3:2] = split_decimal(32'(it.minutes));
        codes[5:4] = split_decimal(32'(it.hours));
      end
      CMD_DATE: begin
        codes[1:0] = split_decimal(32'(it.year) % 32'd100);
        if (mdy) begin
          codes[3:2] = split_decimal(32'(it.day));
          codes[5:4] = split_decimal(32'(it.month));
        end else begin
          codes[3:2] = split_decimal(32'(it.month));
          codes[5:4] = split_decimal(32'(it.day));
        end
      end
      CMD_MSG: begin
        for (k = 0; k < 6; k++) codes[5-k] = it.message_text[8*k +: 8];
      end
      default: blank = 1'b1;
    endcase
    for (k = 0; k < 6; k++)
      tubes[k] = (blank ? 8'h00 : segment_pattern(codes[k])) | {7'b0, it.dot_mask[k]};
    return result_t'(tubes);
  endfunction

  always @(posedge clk_i) begin : monitor
    result_t         want;
    logic [5:0][7:0] w_bytes;
    logic [5:0][7:0] g_bytes;
    logic [5:0]      bad_tubes;
    int              k;
    if (!rst_ni) begin
      month_first = 1'b0;
      fail_count = 0;
      checked_count = 0;
      tube_bytes_q.delete();
    end else begin
      if (result_valid_o) begin
        if (tube_bytes_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: result %h with no command outstanding", $realtime, result_o);
        end else begin
          want = tube_bytes_q.pop_front();
          checked_count++;
          w_bytes = want;
          g_bytes = result_o;
          for (k = 0; k < 6; k++) bad_tubes[k] = (g_bytes[k] !== w_bytes[k]);
          if (bad_tubes != '0) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: tubes 5..0 expected %h got %h (bad tube mask %b)",
                       $realtime, want, result_o, bad_tubes);
          end
        end
      end
      // an item taken at the same edge as a write already sees the new order
      if (cfg_valid_i && cfg_ready_o) month_first = cfg_data_i;
      if (start && !busy) tube_bytes_q.push_back(render_tubes(item_i, month_first));
    end
    failures_o <= fail_count;
    pending_o  <= tube_bytes_q.size();
    results_o  <= checked_count;
  end

endmodule

/* tb/tb_clock_seven_segment_renderer_core.sv */
// Testbench top for clock_seven_segment_renderer_core: directed and random render
// commands under both date orders, with random sender gaps and a drain pause.
// Depends on cssr_pkg, the core and segment_render_checker.
module tb_clock_seven_segment_renderer_core;
  import cssr_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic       ORDER_DMY  = 1'b0;
  localparam logic       ORDER_MDY  = 1'b1;

  logic    clk_i;
  logic    rst_ni;
  logic    start;
  logic    busy;
  item_t   item_i;
  logic    result_valid_o;
  result_t result_o;
  logic    cfg_valid_i;
  logic    cfg_ready_o;
  logic    cfg_data_i;

  int failures;
  int pending;
  int results;
  int cmd_hits[4];
  int cfg_writes;

  clock_seven_segment_renderer_core DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  segment_render_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .failures_o     (failures),
    .pending_o      (pending),
    .results_o      (results)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // unused fields carry random bits
  function automatic item_t noise_item();
    return item_t'({$urandom, $urandom, $urandom});
  endfunction

  function automatic item_t time_cmd(input int unsigned h, input int unsigned m,
                                     input int unsigned s, input logic [5:0] dots);
    item_t it;
    it = noise_item();
    it.cmd = CMD_TIME;
    it.hours = 5'(h);
    it.minutes = 6'(m);
    it.seconds = 6'(s);
    it.dot_mask = dots;
    return it;
  endfunction

  function automatic item_t date_cmd(input int unsigned d, input int unsigned mo,
                                     input int unsigned y, input logic [5:0] dots);
    item_t it;
    it = noise_item();
    it.cmd = CMD_DATE;
    it.day = 5'(d);
    it.month = 4'(mo);
    it.year = 14'(y);
    it.dot_mask = dots;
    return it;
  endfunction

  function automatic item_t msg_cmd(input logic [47:0] text, input logic [5:0] dots);
    item_t it;
    it = noise_item();
    it.cmd = CMD_MSG;
    it.message_text = text;
    it.dot_mask = dots;
    return it;
  endfunction

  function automatic item_t unused_cmd(input logic [5:0] dots);
    item_t it;
    it = noise_item();
    it.cmd = CMD_UNUSED;
    it.dot_mask = dots;
    return it;
  endfunction

  function automatic logic [7:0] random_char();
    string letters;
    string marks;
    int    r;
    letters = "ABCDEFGHIJKLMNOPQRSTUVWXYZ";
    marks = " .-0";
    r = $urandom_range(0, 99);
    if (r < 15) return 8'($urandom_range(0, 9));
    if (r < 60) return letters[$urandom_range(0, 25)];
    if (r < 75) return marks[$urandom_range(0, 3)];
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic item_t random_command();
    item_t it;
    int    r;
    int    k;
    it = noise_item();
    r = $urandom_range(0, 99);
    if (r < 30) begin
      it.cmd = CMD_TIME;
      if ($urandom_range(0, 9) != 0) begin
        it.seconds = 6'($urandom_range(0, 59));
        it.minutes = 6'($urandom_range(0, 59));
        it.hours = 5'($urandom_range(0, 23));
      end
    end else if (r < 60) begin
      it.cmd = CMD_DATE;
      if ($urandom_range(0, 9) != 0) begin
        it.day = 5'($urandom_range(1, 31));
        it.month = 4'($urandom_range(1, 12));
        it.year = 14'($urandom_range(0, 9999));
      end
    end else if (r < 92) begin
      it.cmd = CMD_MSG;
      for (k = 0; k < 6; k++) it.message_text[8*k +: 8] = random_char();
    end else begin
      it.cmd = CMD_UNUSED;
    end
    return it;
  endfunction

  task automatic drive_item(input item_t it);
    @(negedge clk_i);
    start <= 1'b1;
    item_i <= it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    cmd_hits[it.cmd]++;
  endtask

  task automatic maybe_gap();
    if ($urandom_range(0, 99) < 8) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat ($urandom_range(0, 3)) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_date_order(input logic v);
    drain();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    cfg_writes++;
  endtask

  task automatic random_run(input int count, input int quiet_items, input int pause_at);
    int n;
    for (n = 0; n < count; n++) begin
      if (n == pause_at) drain();
      if (n >= quiet_items) maybe_gap();
      drive_item(random_command());
    end
  endtask

  initial begin
    int guard;
    start = 1'b0;
    item_i = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i = 1'b0;
    rst_ni = 1'b0;
    cfg_writes = 0;
    foreach (cmd_hits[k]) cmd_hits[k] = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    write_date_order(ORDER_DMY);
    drive_item(time_cmd(0, 0, 0, 6'h00));
    drive_item(time_cmd(23, 59, 59, 6'h3F));
    drive_item(time_cmd(31, 63, 63, 6'h2A));
    drive_item(time_cmd(12, 34, 56, 6'h15));
    drive_item(time_cmd(9, 9, 9, 6'h01));
    drive_item(date_cmd(1, 1, 0, 6'h00));
    drive_item(date_cmd(31, 12, 9999, 6'h3F));
    drive_item(date_cmd(31, 15, 16383, 6'h20));
    drive_item(date_cmd(0, 0, 2000, 6'h3F));
    drive_item(msg_cmd("      ", 6'h00));
    drive_item(msg_cmd("ABCDEF", 6'h01));
    drive_item(msg_cmd("GHIJLN", 6'h02));
    drive_item(msg_cmd("OPQRST", 6'h04));
    drive_item(msg_cmd("UVY.-0", 6'h08));
    drive_item(msg_cmd("KMWXZ?", 6'h10));
    drive_item(msg_cmd(48'h000102030405, 6'h3F));
    drive_item(msg_cmd(48'h060708090AFF, 6'h00));
    drive_item(msg_cmd(48'hFFFFFFFFFFFF, 6'h15));
    drive_item(msg_cmd(48'h000000000000, 6'h2A));
    drive_item(msg_cmd(48'h80412E2D3020, 6'h00));
    drive_item(unused_cmd(6'h3F));
    drive_item(unused_cmd(6'h00));

    write_date_order(ORDER_MDY);
    drive_item(date_cmd(31, 12, 9999, 6'h00));
    drive_item(date_cmd(1, 1, 0, 6'h3F));
    drive_item(date_cmd(17, 8, 1987, 6'h0A));
    random_run(130, 0, -1);

    write_date_order(ORDER_DMY);
    random_run(130, 60, -1);

    write_date_order(ORDER_MDY);
    random_run(140, 0, 70);

    @(negedge clk_i);
    start <= 1'b0;
    guard = 0;
    while (pending != 0 && guard < 1000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (5) @(posedge clk_i);

    $display("Sent %0d commands: %0d time, %0d date, %0d message, %0d unused code",
             cmd_hits[0] + cmd_hits[1] + cmd_hits[2] + cmd_hits[3],
             cmd_hits[CMD_TIME], cmd_hits[CMD_DATE], cmd_hits[CMD_MSG], cmd_hits[CMD_UNUSED]);
    $display("%0d date order writes, %0d result transactions checked", cfg_writes, results);
    if (pending != 0) $display("%0d results never arrived", pending);
    if (failures == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* clock_seven_segment_renderer_core.f */
+incdir+sv
sv/cssr_pkg.sv
sv/cssr_split.sv
sv/cssr_glyph.sv
sv/clock_seven_segment_renderer_core.sv
tb/segment_render_checker.sv
tb/tb_clock_seven_segment_renderer_core.sv
